// ===== rtl/i2cm_pkg.sv =====
// Shared types, phase codes and constants for the I2C master bit engine.
package i2cm_pkg;

  // Default width of the phase tick counter.
  localparam int TICK_WIDTH_DEFAULT = 17;

  // Reset value of the half-period register.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;

  // Address byte handling for the start-with-address commands.
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;

  // Last bit position of a byte.
  localparam logic [3:0] LAST_BIT = 4'd7;

  // Command codes.
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_READ_ACK = 3'd3;
  localparam logic [2:0] OP_READ_NAK = 3'd4;
  localparam logic [2:0] OP_ADDR_WR  = 3'd5;
  localparam logic [2:0] OP_ADDR_RD  = 3'd6;
  // The one code that is not a command; the engine ignores it.
  localparam logic [2:0] OP_UNUSED   = 3'd7;

  // Phase codes.
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_S1   = 5'd1;
  localparam logic [4:0] PH_S2   = 5'd2;
  localparam logic [4:0] PH_S3   = 5'd3;
  localparam logic [4:0] PH_P1   = 5'd4;
  localparam logic [4:0] PH_P2   = 5'd5;
  localparam logic [4:0] PH_P3   = 5'd6;
  localparam logic [4:0] PH_WSET = 5'd7;
  localparam logic [4:0] PH_WSTR = 5'd8;
  localparam logic [4:0] PH_WHI  = 5'd9;
  localparam logic [4:0] PH_WLO  = 5'd10;
  localparam logic [4:0] PH_ASET = 5'd11;
  localparam logic [4:0] PH_ASTR = 5'd12;
  localparam logic [4:0] PH_AHI  = 5'd13;
  localparam logic [4:0] PH_ALO  = 5'd14;
  localparam logic [4:0] PH_RHI  = 5'd15;
  localparam logic [4:0] PH_RLO  = 5'd16;
  localparam logic [4:0] PH_KSET = 5'd17;
  localparam logic [4:0] PH_KHI  = 5'd18;
  localparam logic [4:0] PH_KLO  = 5'd19;
  localparam logic [4:0] PH_KREL = 5'd20;

  // One input beat: a tick with an optional command and the sampled pins.
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       scl_sense;
    logic       sda_sense;
  } in_beat_t;

  // One output beat: pin drives and status for that tick.
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       acked;
  } out_beat_t;

  // Engine state apart from the tick counter.
  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic       ack_flag;
    logic       scl_drive;
    logic       sda_drive;
    logic [2:0] pending_op;
    logic [7:0] last_read;
  } eng_state_t;

endpackage

// ===== rtl/i2cm_step.sv =====
// Next-state and result logic for one tick of the I2C master bit engine.
module i2cm_step #(
  parameter int TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEFAULT
) (
  input  i2cm_pkg::eng_state_t  cur,
  input  logic [TICK_WIDTH-1:0] tick,
  input  logic [15:0]           half_period_ticks,
  input  i2cm_pkg::in_beat_t    beat,
  output i2cm_pkg::eng_state_t  nxt,
  output logic [TICK_WIDTH-1:0] tick_next,
  output i2cm_pkg::out_beat_t   res
);
  import i2cm_pkg::*;

  localparam int CW = ((TICK_WIDTH > 17) ? TICK_WIDTH : 17) + 1;

  logic [CW-1:0] tick_max;
  logic [16:0]   half_eff;
  logic [16:0]   len_raw;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] len_sat;
  logic          dbl;
  logic          last_tick;
  logic          do_enter;
  logic [4:0]    ent;
  logic          done;

  // Phase length: H or 2H, with a zero half period taken as one tick,
  // saturated at what the tick counter can hold.
  always_comb begin
    tick_max = CW'({TICK_WIDTH{1'b1}});
    half_eff = (half_period_ticks == 16'd0) ? 17'd1 : {1'b0, half_period_ticks};
    dbl = (cur.phase == PH_S2) || (cur.phase == PH_P2) || (cur.phase == PH_WHI) ||
          (cur.phase == PH_AHI) || (cur.phase == PH_RHI) || (cur.phase == PH_RLO) ||
          (cur.phase == PH_KHI);
    len_raw = dbl ? {half_eff[15:0], 1'b0} : half_eff;
    len_ext = CW'(len_raw);
    len_sat = (len_ext > tick_max) ? tick_max : len_ext;
    last_tick = (CW'(tick) + CW'(1)) >= len_sat;
  end

  // Phase sequencing.
  always_comb begin
    nxt       = cur;
    tick_next = tick;
    do_enter  = 1'b0;
    ent       = PH_IDLE;
    done      = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (beat.cmd_valid && (beat.operation != OP_UNUSED)) begin
        nxt.pending_op = beat.operation;
        nxt.bit_index  = 4'd0;
        do_enter       = 1'b1;
        unique case (beat.operation)
          OP_START: ent = PH_S1;
          OP_STOP: ent = PH_P1;
          OP_WRITE: begin
            nxt.shift_byte = beat.write_data;
            ent = PH_WSET;
          end
          OP_READ_ACK, OP_READ_NAK: begin
            nxt.shift_byte = 8'd0;
            ent = PH_RHI;
          end
          OP_ADDR_WR: begin
            nxt.shift_byte = beat.write_data & ADDR_WR_MASK;
            ent = PH_S1;
          end
          default: begin
            nxt.shift_byte = beat.write_data | ADDR_RD_BIT;
            ent = PH_S1;
          end
        endcase
      end
    end else if ((cur.phase == PH_WSTR) || (cur.phase == PH_ASTR)) begin
      // Clock stretching: hold until the slave lets SCL go high.
      if (beat.scl_sense) begin
        do_enter = 1'b1;
        ent = (cur.phase == PH_WSTR) ? PH_WHI : PH_AHI;
      end
    end else if (!last_tick) begin
      tick_next = tick + TICK_WIDTH'(1);
    end else begin
      do_enter = 1'b1;
      unique case (cur.phase)
        PH_S1: ent = PH_S2;
        PH_S2: ent = PH_S3;
        PH_S3: begin
          if ((cur.pending_op == OP_ADDR_WR) || (cur.pending_op == OP_ADDR_RD)) begin
            nxt.bit_index = 4'd0;
            ent = PH_WSET;
          end else begin
            do_enter = 1'b0;
            done = 1'b1;
          end
        end
        PH_P1: ent = PH_P2;
        PH_P2: ent = PH_P3;
        PH_WSET: ent = PH_WSTR;
        PH_WHI: ent = PH_WLO;
        PH_WLO: begin
          if (cur.bit_index >= LAST_BIT) begin
            ent = PH_ASET;
          end else begin
            nxt.bit_index  = cur.bit_index + 4'd1;
            nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
            ent = PH_WSET;
          end
        end
        PH_ASET: ent = PH_ASTR;
        PH_AHI: begin
          nxt.ack_flag = ~beat.sda_sense;
          ent = PH_ALO;
        end
        PH_RHI: begin
          nxt.shift_byte = {cur.shift_byte[6:0], beat.sda_sense};
          ent = PH_RLO;
        end
        PH_RLO: begin
          if (cur.bit_index >= LAST_BIT) begin
            nxt.last_read = cur.shift_byte;
            ent = PH_KSET;
          end else begin
            nxt.bit_index = cur.bit_index + 4'd1;
            ent = PH_RHI;
          end
        end
        PH_KSET: ent = PH_KHI;
        PH_KHI: ent = PH_KLO;
        PH_KLO: ent = PH_KREL;
        default: begin
          do_enter = 1'b0;
          done = 1'b1;
        end
      endcase
      if (done) begin
        nxt.phase = PH_IDLE;
        tick_next = '0;
      end
    end

    // Entering a phase restarts its timer and sets its pin levels.
    if (do_enter) begin
      nxt.phase = ent;
      tick_next = '0;
      unique case (ent)
        PH_S1, PH_P2, PH_WSTR, PH_ASTR, PH_KHI: nxt.scl_drive = 1'b1;
        PH_S2, PH_P1: nxt.sda_drive = 1'b0;
        PH_S3, PH_WLO, PH_ALO, PH_RLO, PH_KLO: nxt.scl_drive = 1'b0;
        PH_P3, PH_ASET, PH_KREL: nxt.sda_drive = 1'b1;
        PH_WSET: nxt.sda_drive = nxt.shift_byte[7];
        PH_RHI: begin
          nxt.scl_drive = 1'b1;
          nxt.sda_drive = 1'b1;
        end
        PH_KSET: nxt.sda_drive = (nxt.pending_op == OP_READ_NAK);
        default: begin
        end
      endcase
    end
  end

  // Result of this tick.
  always_comb begin
    res.scl_release = nxt.scl_drive;
    res.sda_release = nxt.sda_drive;
    res.busy_res    = (nxt.phase != PH_IDLE);
    res.done_res    = done;
    res.read_data   = nxt.last_read;
    res.acked       = nxt.ack_flag;
  end

endmodule

// ===== rtl/i2c_master_bit_engine_top.sv =====
// A tick beat accepted into the input register passes through the engine step into
// the result register, from which it is offered as a result.
// Throughput: one beat per cycle; the input register takes one more beat while a
// result waits, and stall reaches the input only when both registers are full
// and the result is stalled. Reset: synchronous, active high; the engine returns
// to idle with both lines released, status cleared and the half period at 250.
module i2c_master_bit_engine_top #(
  parameter int TICK_WIDTH = i2cm_pkg::TICK_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import i2cm_pkg::*;

  logic                  in_full;
  in_beat_t              in_reg;
  logic                  adv;
  logic [15:0]           half_period;
  eng_state_t            state;
  eng_state_t            state_next;
  logic [TICK_WIDTH-1:0] tick;
  logic [TICK_WIDTH-1:0] tick_next;
  out_beat_t             res;

  // The held beat moves on when the result register is free or being taken.
  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !adv;

  // Half-period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  // Input beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && !in_stall) || (in_full && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  // One tick of the engine.
  i2cm_step #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_step (
    .cur              (state),
    .tick             (tick),
    .half_period_ticks(half_period),
    .beat             (in_reg),
    .nxt              (state_next),
    .tick_next        (tick_next),
    .res              (res)
  );

  // Engine state advances with each beat that moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_IDLE;
      state.bit_index  <= 4'd0;
      state.shift_byte <= 8'd0;
      state.ack_flag   <= 1'b0;
      state.scl_drive  <= 1'b1;
      state.sda_drive  <= 1'b1;
      state.pending_op <= 3'd0;
      state.last_read  <= 8'd0;
      tick             <= '0;
    end else if (adv) begin
      state <= state_next;
      tick  <= tick_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/i2cm_checker.sv =====
// Port-level assertions for the I2C master bit engine, bound to the top level.
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input i2cm_pkg::out_beat_t out_data
);
  import i2cm_pkg::*;

  // A completing tick already reports the engine as idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done beat reports busy");

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The input side stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result beat present right after reset");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_checker (.*);
